FILE: rtl/core/dtlp_pkg.sv
// Shared constants and result word type for the decimal token list parser.
package dtlp_pkg;

	localparam int MaxTokensDefault = 65535;

	localparam logic [3:0] MaxTokenChars = 4'd11;
	localparam logic [3:0] LengthSat     = 4'd12;

	localparam logic [7:0] AsciiZero = 8'd48;
	localparam logic [7:0] AsciiNine = 8'd57;
	localparam logic [7:0] CharPlus  = 8'd43;
	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] SpaceCode = 8'd32;

	localparam logic [31:0] PosLimit = 32'h7FFF_FFFF;
	localparam logic [31:0] NegLimit = 32'h8000_0000;
	localparam logic [31:0] MagSat   = 32'hFFFF_FFFF;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	typedef struct packed {
		logic signed [31:0] value;
		logic               token_ok;
		logic               is_final;
		logic [15:0]        token_count;
		logic               list_ok;
	} res_t;

endpackage

FILE: rtl/core/decimal_token_list_parser.sv
// Top level: splits a character stream into tokens and converts each to int32.
//
// One character (or end marker) word is taken per cycle whenever in_ready is
// high. Token state (length, sign, magnitude, flags) sits in registers and is
// advanced by one shift-add multiply by ten and one compare per cycle; each
// finished token, and the summary on an end marker, is pushed into a
// four-word result queue that drives the output channel. An end marker that
// closes an open token pushes two words in the same cycle. in_ready drops
// while fewer than two queue slots are free, so a character word is taken
// every cycle as long as out_ready keeps up; the result of an accepted word
// is registered in the queue and is output after the words ahead of it.
module decimal_token_list_parser
	import dtlp_pkg::*;
#(
	parameter int MAX_TOKENS = MaxTokensDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               delimiter_we,
	input  logic [7:0]         delimiter_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               token_ok,
	output logic               is_final,
	output logic [15:0]        token_count,
	output logic               list_ok
);

	localparam logic [15:0] MaxCount = 16'(MAX_TOKENS);

	logic [7:0]  delimiter_q;
	logic        in_token_q;
	logic [3:0]  token_length_q;
	logic        is_negative_q;
	logic [31:0] magnitude_q;
	logic        overflowed_q;
	logic        saw_bad_char_q;
	logic        saw_digit_q;
	logic [15:0] tokens_seen_q;
	logic        any_failure_q;

	logic        in_token_d;
	logic [3:0]  token_length_d;
	logic        is_negative_d;
	logic [31:0] magnitude_d;
	logic        overflowed_d;
	logic        saw_bad_char_d;
	logic        saw_digit_d;
	logic [15:0] tokens_seen_d;
	logic        any_failure_d;

	res_t                 queue_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   fill_q;

	logic        accept;
	logic        pop;
	logic        is_digit;
	logic        is_sign;
	logic [35:0] mag_next;
	logic [31:0] limit;
	logic        tok_ok;
	logic [31:0] tok_value;
	logic [15:0] count_inc;
	res_t        tok_res;
	res_t        fin_res;
	res_t        push0;
	res_t        push1;
	logic [1:0]  n_push;

	assign accept    = in_valid && in_ready;
	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && out_ready;
	assign in_ready  = (fill_q <= (QueuePtrW+1)'(QueueDepth - 2));

	assign is_digit = (char_code inside {[AsciiZero:AsciiNine]});
	assign is_sign  = (char_code == CharPlus) || (char_code == CharMinus);

	// magnitude * 10 + digit as (m << 3) + (m << 1) + d
	assign mag_next = ({4'b0000, magnitude_q} << 3) + ({4'b0000, magnitude_q} << 1)
		+ {32'd0, 4'(char_code - AsciiZero)};

	assign limit  = is_negative_q ? NegLimit : PosLimit;
	assign tok_ok = (token_length_q <= MaxTokenChars) && !saw_bad_char_q && saw_digit_q
		&& !overflowed_q && (magnitude_q <= limit);
	assign tok_value = !tok_ok ? 32'd0 : (is_negative_q ? (32'd0 - magnitude_q) : magnitude_q);
	assign count_inc = (tokens_seen_q < MaxCount) ? (tokens_seen_q + 16'd1) : tokens_seen_q;

	always_comb begin
		tok_res.value       = signed'(tok_value);
		tok_res.token_ok    = tok_ok;
		tok_res.is_final    = 1'b0;
		tok_res.token_count = count_inc;
		tok_res.list_ok     = 1'b0;

		fin_res.value       = '0;
		fin_res.token_ok    = 1'b0;
		fin_res.is_final    = 1'b1;
		fin_res.token_count = in_token_q ? count_inc : tokens_seen_q;
		fin_res.list_ok     = in_token_q ? ((count_inc != '0) && !any_failure_q && tok_ok)
			: ((tokens_seen_q != '0) && !any_failure_q);
	end

	always_comb begin
		in_token_d     = in_token_q;
		token_length_d = token_length_q;
		is_negative_d  = is_negative_q;
		magnitude_d    = magnitude_q;
		overflowed_d   = overflowed_q;
		saw_bad_char_d = saw_bad_char_q;
		saw_digit_d    = saw_digit_q;
		tokens_seen_d  = tokens_seen_q;
		any_failure_d  = any_failure_q;
		push0          = tok_res;
		push1          = fin_res;
		n_push         = 2'd0;

		if (end_of_text || (char_code == delimiter_q)) begin
			// close the open token, if any
			if (in_token_q) begin
				tokens_seen_d = count_inc;
				any_failure_d = any_failure_q || !tok_ok;
			end
			in_token_d     = 1'b0;
			token_length_d = '0;
			is_negative_d  = 1'b0;
			magnitude_d    = '0;
			overflowed_d   = 1'b0;
			saw_bad_char_d = 1'b0;
			saw_digit_d    = 1'b0;
			if (end_of_text) begin
				tokens_seen_d = '0;
				any_failure_d = 1'b0;
				if (in_token_q) begin
					n_push = 2'd2;
				end else begin
					push0  = fin_res;
					n_push = 2'd1;
				end
			end else if (in_token_q) begin
				n_push = 2'd1;
			end
		end else begin
			in_token_d = 1'b1;
			if (token_length_q < LengthSat) begin
				token_length_d = token_length_q + 4'd1;
			end
			if ((token_length_q == '0) && is_sign) begin
				is_negative_d = (char_code == CharMinus);
			end else if (is_digit) begin
				saw_digit_d = 1'b1;
				if (mag_next[35:32] != 4'b0000) begin
					magnitude_d  = MagSat;
					overflowed_d = 1'b1;
				end else begin
					magnitude_d = mag_next[31:0];
				end
			end else begin
				saw_bad_char_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q    <= SpaceCode;
			in_token_q     <= 1'b0;
			token_length_q <= '0;
			is_negative_q  <= 1'b0;
			magnitude_q    <= '0;
			overflowed_q   <= 1'b0;
			saw_bad_char_q <= 1'b0;
			saw_digit_q    <= 1'b0;
			tokens_seen_q  <= '0;
			any_failure_q  <= 1'b0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			fill_q         <= '0;
		end else begin
			if (delimiter_we) begin
				delimiter_q <= delimiter_wdata;
			end
			if (accept) begin
				in_token_q     <= in_token_d;
				token_length_q <= token_length_d;
				is_negative_q  <= is_negative_d;
				magnitude_q    <= magnitude_d;
				overflowed_q   <= overflowed_d;
				saw_bad_char_q <= saw_bad_char_d;
				saw_digit_q    <= saw_digit_d;
				tokens_seen_q  <= tokens_seen_d;
				any_failure_q  <= any_failure_d;
				wr_ptr_q       <= wr_ptr_q + QueuePtrW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (accept ? (QueuePtrW+1)'(n_push) : '0)
				- (pop ? (QueuePtrW+1)'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (n_push != 2'd0)) begin
			queue_q[wr_ptr_q] <= push0;
			if (n_push == 2'd2) begin
				queue_q[wr_ptr_q + 1'b1] <= push1;
			end
		end
	end

	assign value       = queue_q[rd_ptr_q].value;
	assign token_ok    = queue_q[rd_ptr_q].token_ok;
	assign is_final    = queue_q[rd_ptr_q].is_final;
	assign token_count = queue_q[rd_ptr_q].token_count;
	assign list_ok     = queue_q[rd_ptr_q].list_ok;

endmodule
